[rtl/adaptive_change_detector_core_macros.svh]
// ----------------------------------------------------------------------------
// Adaptive change detector assertion macros
// Concurrent assertion shorthands, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_CHANGE_DETECTOR_CORE_MACROS_SVH
`define ADAPTIVE_CHANGE_DETECTOR_CORE_MACROS_SVH

// same-cycle implication
`define ACD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("adaptive change detector assertion failed");

// next-cycle implication
`define ACD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("adaptive change detector assertion failed");

`endif

[rtl/acd_pkg.sv]
// ----------------------------------------------------------------------------
// Adaptive change detector package
// Widths, window length and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

  localparam int WINDOW    = 5;

  localparam int SAMPLE_W  = 24;
  localparam int DIFF_W    = 24;
  localparam int SUM_W     = DIFF_W + $clog2(WINDOW);
  localparam int FRAC_W    = 8;
  localparam int AVG_W     = SUM_W + FRAC_W;
  localparam int CNT_W     = 32;
  localparam int POS_W     = 32;
  localparam int THR_W     = 27;
  localparam int RATIO_W   = 8;
  localparam int RATIO_FRAC_W = 4;
  localparam int PROD_W    = AVG_W + RATIO_W;
  localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int STEP_W    = $clog2(AVG_W);

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVITY_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_RATIO      = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1280);
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(56);

endpackage

`default_nettype wire

[rtl/adaptive_change_detector_core.sv]
// ----------------------------------------------------------------------------
// Adaptive change detector core
// Flags samples whose windowed activity exceeds the cumulative event mean.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_stall_o carries one signed Q16.8 sample per
// transaction; output channel out_valid_o/out_stall_i carries the stream
// index and value of a flagged sample. Configuration writes (index 0:
// activity threshold, index 1: outlier ratio) use cfg_valid_i/cfg_ready_o
// and are always ready; write them only while the block is idle.
// One sample is handled at a time. The first WINDOW samples only fill the
// window; later ones pass sum and check. A first event goes on to emit; a
// later one runs a bit-serial divider over AVG_W (35) bits for the mean
// update, an update step, a bit-serial multiplier over RATIO_W (8) bits
// for the outlier test, compare and emit. A result appears on the output
// register in the cycle after the emit step. The result register lets the
// next sample be taken while a result waits; a stalled receiver only holds
// the core when a further result is ready. Reset clears all state, restores
// the register defaults and restarts the warm-up.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_change_detector_core
  import acd_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0]  sample_i,

  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [POS_W-1:0]            sample_index_o,
  output      logic signed [SAMPLE_W-1:0]  sample_value_o,

  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_DIV,
    S_UPD,
    S_MUL,
    S_CMP,
    S_EMIT
  } state_e;

  state_e                state_q;

  logic [THR_W-1:0]      thr_q;
  logic [RATIO_W-1:0]    ratio_q;

  logic [SAMPLE_W-1:0]   samp_q [WINDOW-1];
  logic [DIFF_W-1:0]     diff_q [WINDOW];
  logic [DIFF_W-1:0]     ad_q;
  logic [SUM_W-1:0]      sum_q;
  logic [AVG_W-1:0]      avg_q;
  logic [AVG_W-1:0]      prev_q;
  logic [CNT_W-1:0]      event_cnt_q;
  logic [POS_W-1:0]      pos_q;
  logic [FILL_W-1:0]     fill_q;

  logic [POS_W-1:0]      item_pos_q;
  logic [SAMPLE_W-1:0]   item_val_q;

  logic                  down_q;
  logic [AVG_W-1:0]      dvd_q;
  logic [CNT_W-1:0]      rem_q;
  logic [STEP_W-1:0]     step_q;
  logic [PROD_W-1:0]     mcand_q;
  logic [PROD_W-1:0]     prod_q;
  logic [RATIO_W-1:0]    mult_q;
  logic                  emit_q;

  logic                  out_valid_q;
  logic [POS_W-1:0]      out_index_q;
  logic [SAMPLE_W-1:0]   out_value_q;

  logic signed [SAMPLE_W:0] delta;
  logic [SAMPLE_W:0]     delta_neg;
  logic [DIFF_W-1:0]     abs_delta;
  logic [SUM_W-1:0]      sum_d;
  logic [AVG_W-1:0]      scaled;
  logic                  is_event;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W:0]        trial;
  logic [CNT_W:0]        trial_sub;
  logic                  trial_fits;
  logic [CNT_W-1:0]      rem_d;
  logic [AVG_W-1:0]      avg_d;
  logic [PROD_W-1:0]     scaled_ext;
  logic                  outlier;
  logic [AVG_W-1:0]      avg_final;
  logic                  in_accept;
  logic                  out_free;
  logic                  out_load;

  assign in_stall_o     = (state_q != S_IDLE);
  assign in_accept      = in_valid_i && !in_stall_o;
  assign out_valid_o    = out_valid_q;
  assign sample_index_o = out_index_q;
  assign sample_value_o = out_value_q;
  assign cfg_ready_o    = 1'b1;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_load       = (state_q == S_EMIT) && emit_q && out_free;

  always_comb begin
    delta      = {sample_i[SAMPLE_W-1], sample_i}
               - {samp_q[WINDOW-2][SAMPLE_W-1], samp_q[WINDOW-2]};
    delta_neg  = -delta;
    abs_delta  = delta[SAMPLE_W] ? delta_neg[DIFF_W-1:0] : delta[DIFF_W-1:0];
    sum_d      = sum_q - SUM_W'(diff_q[WINDOW-1]) + SUM_W'(ad_q);
    scaled     = {sum_q, {FRAC_W{1'b0}}};
    is_event   = CMP_W'(sum_q) > CMP_W'(thr_q);
    cnt_inc    = (event_cnt_q == '1) ? event_cnt_q : event_cnt_q + CNT_W'(1);
    trial      = {rem_q, dvd_q[AVG_W-1]};
    trial_sub  = trial - {1'b0, event_cnt_q};
    trial_fits = (trial >= {1'b0, event_cnt_q});
    rem_d      = trial_fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    avg_d      = down_q ? (prev_q - dvd_q - AVG_W'(rem_q != '0)) : (prev_q + dvd_q);
    scaled_ext = PROD_W'({scaled, {RATIO_FRAC_W{1'b0}}});
    outlier    = scaled_ext > prod_q;
    avg_final  = outlier ? prev_q : avg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THR_RESET;
      ratio_q <= RATIO_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ACTIVITY_THRESHOLD: thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_OUTLIER_RATIO:      ratio_q <= cfg_data_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for (int i = 0; i < WINDOW - 1; i++) samp_q[i] <= '0;
      for (int i = 0; i < WINDOW; i++) diff_q[i] <= '0;
      ad_q        <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      prev_q      <= '0;
      event_cnt_q <= '0;
      pos_q       <= '0;
      fill_q      <= '0;
      item_pos_q  <= '0;
      item_val_q  <= '0;
      down_q      <= 1'b0;
      dvd_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      mcand_q     <= '0;
      prod_q      <= '0;
      mult_q      <= '0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_index_q <= '0;
      out_value_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            samp_q[0] <= sample_i;
            for (int i = 1; i < WINDOW - 1; i++) samp_q[i] <= samp_q[i-1];
            pos_q      <= pos_q + POS_W'(1);
            item_pos_q <= pos_q;
            item_val_q <= sample_i;
            ad_q       <= abs_delta;
            if (fill_q < FILL_W'(WINDOW)) begin
              fill_q <= fill_q + FILL_W'(1);
            end else begin
              state_q <= S_SUM;
            end
          end
        end
        S_SUM: begin
          sum_q     <= sum_d;
          diff_q[0] <= ad_q;
          for (int i = 1; i < WINDOW; i++) diff_q[i] <= diff_q[i-1];
          state_q   <= S_CHECK;
        end
        S_CHECK: begin
          if (!is_event) begin
            state_q <= S_IDLE;
          end else if (event_cnt_q == '0) begin
            event_cnt_q <= CNT_W'(1);
            avg_q       <= scaled;
            prev_q      <= scaled;
            emit_q      <= 1'b1;
            state_q     <= S_EMIT;
          end else begin
            event_cnt_q <= cnt_inc;
            prev_q      <= avg_q;
            down_q      <= (scaled < avg_q);
            dvd_q       <= (scaled < avg_q) ? (avg_q - scaled) : (scaled - avg_q);
            rem_q       <= '0;
            step_q      <= STEP_W'(AVG_W - 1);
            state_q     <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= rem_d;
          dvd_q  <= {dvd_q[AVG_W-2:0], trial_fits};
          step_q <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          avg_q   <= avg_d;
          mcand_q <= PROD_W'(avg_d);
          prod_q  <= '0;
          mult_q  <= ratio_q;
          step_q  <= STEP_W'(RATIO_W - 1);
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (mult_q[0]) begin
            prod_q <= prod_q + mcand_q;
          end
          mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
          mult_q  <= {1'b0, mult_q[RATIO_W-1:1]};
          step_q  <= step_q - STEP_W'(1);
          if (step_q == '0) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          avg_q   <= avg_final;
          emit_q  <= (scaled > avg_final);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (!emit_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_index_q <= item_pos_q;
            out_value_q <= item_val_q;
            emit_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "adaptive_change_detector_core_macros.svh"

  `ACD_ASSERT_IMPL(a_div_nonzero, state_q == S_DIV, event_cnt_q >= CNT_W'(2))
  `ACD_ASSERT_IMPL(a_div_rem, state_q == S_DIV, rem_q < event_cnt_q)
  `ACD_ASSERT_NEXT(a_div_done, state_q == S_DIV && step_q == '0, state_q == S_UPD)
  `ACD_ASSERT_IMPL(a_out_from_emit, $rose(out_valid_q), $past(state_q == S_EMIT))
  `ACD_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FILL_W'(WINDOW))

endmodule

`default_nettype wire
